// File: sv/blr_pkg.sv
`timescale 1ns / 1ps

package blr_pkg;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int PIX_W     = 6;
  localparam int GLYPH_W   = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] SCREEN_SIDE_RESET = 7'd64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic cap;
    logic setup;
    logic step;
    logic take;
    logic emit_mid;
    logic emit_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic vis;
    logic pend_valid;
    logic at_stop;
    logic out_free;
  } dp_status_t;

endpackage

// File: sv/bresenham_line_rasterizer_top.sv
`timescale 1ns / 1ps

// Bresenham line rasterizer. Each input transaction is one line command with
// two signed endpoints and a glyph; the block walks the line along its major
// axis from the endpoint with the smaller major coordinate and produces one
// output transaction per point that falls inside the configured screen, with
// last set on the final one. A line with no visible point yields a single
// transaction with has_pixel clear and last set. A command walks N =
// |major-axis delta| + 1 points (up to 2^COORD_BITS): the command is captured,
// then set up, then the single stepping unit walks the points in turn, and
// finally the last result is written. Output stalls hold the command only when
// a result, a visible point or the final one, must wait for the result
// register. Screen width and height may be written only while no command is in
// flight; values above MAX_SIDE act as MAX_SIDE.
module bresenham_line_rasterizer_top #(
  parameter int COORD_BITS = 8,
  parameter int MAX_SIDE   = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [COORD_BITS-1:0]               in_start_x,
  input  logic [COORD_BITS-1:0]               in_start_y,
  input  logic [COORD_BITS-1:0]               in_end_x,
  input  logic [COORD_BITS-1:0]               in_end_y,
  input  logic [blr_pkg::GLYPH_W-1:0]         in_glyph,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [blr_pkg::PIX_W-1:0]           out_pixel_x,
  output logic [blr_pkg::PIX_W-1:0]           out_pixel_y,
  output logic [blr_pkg::GLYPH_W-1:0]         out_pixel_glyph,
  output logic                                out_has_pixel,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  logic [blr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [blr_pkg::CFG_W-1:0]           cfg_data
);

  blr_pkg::ctrl_cmd_t  cmd;
  blr_pkg::dp_status_t status;

  blr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  blr_datapath #(
    .COORD_BITS (COORD_BITS),
    .MAX_SIDE   (MAX_SIDE)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_glyph        (in_glyph),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_glyph (out_pixel_glyph),
    .out_has_pixel   (out_has_pixel),
    .out_last        (out_last)
  );

endmodule

// File: sv/blr_ctrl.sv
`timescale 1ns / 1ps

module blr_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  blr_pkg::dp_status_t    status,
  output blr_pkg::ctrl_cmd_t     cmd
);

  blr_pkg::state_t state_r;
  blr_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= blr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      blr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = blr_pkg::ST_SETUP;
        end
      end
      blr_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = blr_pkg::ST_RUN;
      end
      blr_pkg::ST_RUN: begin
        if (!(status.vis && status.pend_valid && !status.out_free)) begin
          cmd.take     = status.vis;
          cmd.emit_mid = status.vis && status.pend_valid;
          if (status.at_stop) begin
            state_nxt = blr_pkg::ST_FLUSH;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      blr_pkg::ST_FLUSH: begin
        if (status.out_free) begin
          cmd.emit_last = 1'b1;
          state_nxt     = blr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = blr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/blr_datapath.sv
`timescale 1ns / 1ps

module blr_datapath #(
  parameter int COORD_BITS = 8,
  parameter int MAX_SIDE   = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [COORD_BITS-1:0]               in_start_x,
  input  logic [COORD_BITS-1:0]               in_start_y,
  input  logic [COORD_BITS-1:0]               in_end_x,
  input  logic [COORD_BITS-1:0]               in_end_y,
  input  logic [blr_pkg::GLYPH_W-1:0]         in_glyph,
  input  logic                                cfg_we,
  input  logic [blr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [blr_pkg::CFG_W-1:0]           cfg_data,
  input  blr_pkg::ctrl_cmd_t                  cmd,
  output blr_pkg::dp_status_t                 status,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [blr_pkg::PIX_W-1:0]           out_pixel_x,
  output logic [blr_pkg::PIX_W-1:0]           out_pixel_y,
  output logic [blr_pkg::GLYPH_W-1:0]         out_pixel_glyph,
  output logic                                out_has_pixel,
  output logic                                out_last
);

  localparam int CW  = COORD_BITS;
  localparam int DW  = COORD_BITS + 1;
  localparam int EW  = COORD_BITS + 3;
  localparam int LW  = blr_pkg::CFG_W;
  localparam int PW  = blr_pkg::PIX_W;
  localparam int GW  = blr_pkg::GLYPH_W;

  logic [LW-1:0] width_r, height_r;
  logic [LW-1:0] lim_w_r, lim_h_r;
  logic [CW-1:0] x1_r, y1_r, x2_r, y2_r;
  logic [GW-1:0] glyph_r;

  logic signed [CW-1:0] x_r, y_r, x_nxt, y_nxt, stop_r;
  logic signed [EW-1:0] err_r, err_nxt, keep_r, turn_r;
  logic                 xmaj_r, step_neg_r;

  logic          pend_valid_r;
  logic [PW-1:0] pend_x_r, pend_y_r;

  logic          out_valid_r;
  logic [PW-1:0] out_x_r, out_y_r;
  logic [GW-1:0] out_glyph_r;
  logic          out_has_r, out_last_r;

  logic signed [DW-1:0] dx, dy, adx, ady;
  logic signed [EW-1:0] adx2, ady2, adx_e, ady_e;
  logic                 dx_pos, dy_pos, xmaj, same_sign;
  logic signed [CW-1:0] sx, sy, sstop;
  logic signed [EW-1:0] keep0, turn0, err0;
  logic                 take_minor;
  logic signed [CW-1:0] minor_inc;
  logic                 x_vis, y_vis, out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= blr_pkg::SCREEN_SIDE_RESET;
      height_r <= blr_pkg::SCREEN_SIDE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        blr_pkg::REG_SCREEN_WIDTH:  width_r  <= cfg_data;
        blr_pkg::REG_SCREEN_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Setup arithmetic on the captured endpoints.
  always_comb begin
    dx     = {x2_r[CW-1], x2_r} - {x1_r[CW-1], x1_r};
    dy     = {y2_r[CW-1], y2_r} - {y1_r[CW-1], y1_r};
    adx    = dx[DW-1] ? -dx : dx;
    ady    = dy[DW-1] ? -dy : dy;
    dx_pos = !dx[DW-1] && (dx != '0);
    dy_pos = !dy[DW-1] && (dy != '0);
    same_sign = (dx[DW-1] && dy[DW-1]) || (dx_pos && dy_pos);
    xmaj   = (ady <= adx);
    adx_e  = {{(EW-DW){1'b0}}, adx};
    ady_e  = {{(EW-DW){1'b0}}, ady};
    adx2   = {adx_e[EW-2:0], 1'b0};
    ady2   = {ady_e[EW-2:0], 1'b0};
    if (xmaj) begin
      keep0 = ady2;
      turn0 = ady2 - adx2;
      err0  = ady2 - adx_e;
      if (!dx[DW-1]) begin
        sx = x1_r; sy = y1_r; sstop = x2_r;
      end else begin
        sx = x2_r; sy = y2_r; sstop = x1_r;
      end
    end else begin
      keep0 = adx2;
      turn0 = adx2 - ady2;
      err0  = adx2 - ady_e;
      if (!dy[DW-1]) begin
        sx = x1_r; sy = y1_r; sstop = y2_r;
      end else begin
        sx = x2_r; sy = y2_r; sstop = y1_r;
      end
    end
  end

  // One Bresenham step along the major axis.
  always_comb begin
    take_minor = xmaj_r ? !err_r[EW-1] : (!err_r[EW-1] && (err_r != '0));
    minor_inc  = step_neg_r ? {CW{1'b1}} : CW'(1);
    err_nxt    = take_minor ? (err_r + turn_r) : (err_r + keep_r);
    x_nxt      = x_r;
    y_nxt      = y_r;
    if (xmaj_r) begin
      x_nxt = x_r + CW'(1);
      if (take_minor) begin
        y_nxt = y_r + minor_inc;
      end
    end else begin
      y_nxt = y_r + CW'(1);
      if (take_minor) begin
        x_nxt = x_r + minor_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      x1_r    <= in_start_x;
      y1_r    <= in_start_y;
      x2_r    <= in_end_x;
      y2_r    <= in_end_y;
      glyph_r <= in_glyph;
      lim_w_r <= (width_r > LW'(MAX_SIDE)) ? LW'(MAX_SIDE) : width_r;
      lim_h_r <= (height_r > LW'(MAX_SIDE)) ? LW'(MAX_SIDE) : height_r;
    end
    if (cmd.setup) begin
      x_r        <= sx;
      y_r        <= sy;
      stop_r     <= sstop;
      err_r      <= err0;
      keep_r     <= keep0;
      turn_r     <= turn0;
      xmaj_r     <= xmaj;
      step_neg_r <= !same_sign;
    end else if (cmd.step) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      err_r <= err_nxt;
    end
  end

  always_comb begin
    x_vis = !x_r[CW-1] && ({1'b0, x_r} < {{(DW-LW){1'b0}}, lim_w_r});
    y_vis = !y_r[CW-1] && ({1'b0, y_r} < {{(DW-LW){1'b0}}, lim_h_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.cap) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.take) begin
      pend_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pend_x_r <= x_r[PW-1:0];
      pend_y_r <= y_r[PW-1:0];
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_mid || cmd.emit_last) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_mid) begin
      out_x_r     <= pend_x_r;
      out_y_r     <= pend_y_r;
      out_glyph_r <= glyph_r;
      out_has_r   <= 1'b1;
      out_last_r  <= 1'b0;
    end else if (cmd.emit_last) begin
      out_x_r     <= pend_valid_r ? pend_x_r : '0;
      out_y_r     <= pend_valid_r ? pend_y_r : '0;
      out_glyph_r <= pend_valid_r ? glyph_r : '0;
      out_has_r   <= pend_valid_r;
      out_last_r  <= 1'b1;
    end
  end

  always_comb begin
    status.vis        = x_vis && y_vis;
    status.pend_valid = pend_valid_r;
    status.at_stop    = (xmaj_r ? x_r : y_r) == stop_r;
    status.out_free   = out_free;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_pixel_glyph = out_glyph_r;
  assign out_has_pixel   = out_has_r;
  assign out_last        = out_last_r;

endmodule
